### rtl/pidaw_pkg.sv
// Shared types and constants for the fixed-point PID controller with anti-windup.
// Used by the register block, the iterative multiplier/divider and the top level.
`default_nettype none

package pidaw_pkg;

	localparam int ADDR_W    = 5;
	localparam int MUL_A_W   = 49;
	localparam int MUL_B_W   = 33;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);
	localparam int DIV_N_W   = 66;
	localparam int DIV_D_W   = 32;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;
	localparam logic [48:0] TERM_LIM  = 49'h0_0100_0000_0000;
	localparam logic [48:0] SLOPE_LIM = 49'h0_8000_0000_0000;
	localparam logic [16:0] ONE_Q16   = 17'h1_0000;

	localparam logic [31:0]        KP_RST   = 32'd65536000;
	localparam logic [31:0]        KI_RST   = 32'd3276800;
	localparam logic [31:0]        KD_RST   = 32'd6553600;
	localparam logic [15:0]        PER_RST  = 16'd655;
	localparam logic [16:0]        FC_RST   = 17'd6554;
	localparam logic signed [15:0] OMIN_RST = -16'sd5000;
	localparam logic signed [15:0] OMAX_RST = 16'sd3000;

	typedef enum logic [2:0] {
		REG_KP   = 3'd0,
		REG_KI   = 3'd1,
		REG_KD   = 3'd2,
		REG_PER  = 3'd3,
		REG_FC   = 3'd4,
		REG_OMIN = 3'd5,
		REG_OMAX = 3'd6,
		REG_AW   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]        kp;
		logic [31:0]        ki;
		logic [31:0]        kd;
		logic [15:0]        per;
		logic [16:0]        fc;
		logic signed [15:0] omin;
		logic signed [15:0] omax;
		logic               aw;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/pidaw_regs.sv
// APB-style configuration registers of the PID controller.
// Depends on pidaw_pkg for the register map and the cfg_t bundle.
`default_nettype none

module pidaw_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [pidaw_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output pidaw_pkg::cfg_t                 cfg
);

	pidaw_pkg::cfg_t    cfg_q;
	pidaw_pkg::reg_idx_t idx;

	assign idx = pidaw_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp   <= pidaw_pkg::KP_RST;
			cfg_q.ki   <= pidaw_pkg::KI_RST;
			cfg_q.kd   <= pidaw_pkg::KD_RST;
			cfg_q.per  <= pidaw_pkg::PER_RST;
			cfg_q.fc   <= pidaw_pkg::FC_RST;
			cfg_q.omin <= pidaw_pkg::OMIN_RST;
			cfg_q.omax <= pidaw_pkg::OMAX_RST;
			cfg_q.aw   <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				pidaw_pkg::REG_KP:   cfg_q.kp   <= pwdata;
				pidaw_pkg::REG_KI:   cfg_q.ki   <= pwdata;
				pidaw_pkg::REG_KD:   cfg_q.kd   <= pwdata;
				pidaw_pkg::REG_PER:  cfg_q.per  <= pwdata[15:0];
				pidaw_pkg::REG_FC:   cfg_q.fc   <= pwdata[16:0];
				pidaw_pkg::REG_OMIN: cfg_q.omin <= $signed(pwdata[15:0]);
				pidaw_pkg::REG_OMAX: cfg_q.omax <= $signed(pwdata[15:0]);
				pidaw_pkg::REG_AW:   cfg_q.aw   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			pidaw_pkg::REG_KP:   prdata = cfg_q.kp;
			pidaw_pkg::REG_KI:   prdata = cfg_q.ki;
			pidaw_pkg::REG_KD:   prdata = cfg_q.kd;
			pidaw_pkg::REG_PER:  prdata = {16'b0, cfg_q.per};
			pidaw_pkg::REG_FC:   prdata = {15'b0, cfg_q.fc};
			pidaw_pkg::REG_OMIN: prdata = {16'b0, cfg_q.omin};
			pidaw_pkg::REG_OMAX: prdata = {16'b0, cfg_q.omax};
			pidaw_pkg::REG_AW:   prdata = {31'b0, cfg_q.aw};
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### rtl/pidaw_mul.sv
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on pidaw_pkg for operand widths.
`default_nettype none

module pidaw_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pidaw_pkg::MUL_A_W-1:0] a,
	input  wire logic [pidaw_pkg::MUL_B_W-1:0] b,
	output logic                               done,
	output logic [pidaw_pkg::MUL_P_W-1:0]      prod
);

	logic                              busy_q;
	logic                              done_q;
	logic [pidaw_pkg::MUL_CNT_W-1:0]   cnt_q;
	logic [pidaw_pkg::MUL_P_W-1:0]     a_q;
	logic [pidaw_pkg::MUL_B_W-1:0]     b_q;
	logic [pidaw_pkg::MUL_P_W-1:0]     acc_q;

	assign done = done_q;
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pidaw_pkg::MUL_CNT_W'(pidaw_pkg::MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q   <= {{pidaw_pkg::MUL_B_W{1'b0}}, a};
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= {a_q[pidaw_pkg::MUL_P_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[pidaw_pkg::MUL_B_W-1:1]};
		end
	end

endmodule

`default_nettype wire

### rtl/pidaw_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pidaw_pkg for operand widths.
`default_nettype none

module pidaw_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pidaw_pkg::DIV_N_W-1:0] num,
	input  wire logic [pidaw_pkg::DIV_D_W-1:0] den,
	output logic                               done,
	output logic [pidaw_pkg::DIV_N_W-1:0]      quot
);

	logic                            busy_q;
	logic                            done_q;
	logic [pidaw_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [pidaw_pkg::DIV_N_W-1:0]   num_q;
	logic [pidaw_pkg::DIV_D_W-1:0]   den_q;
	logic [pidaw_pkg::DIV_D_W-1:0]   rem_q;
	logic [pidaw_pkg::DIV_D_W:0]     trial;
	logic [pidaw_pkg::DIV_D_W:0]     diff;
	logic                            qbit;

	assign trial = {rem_q, num_q[pidaw_pkg::DIV_N_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = !diff[pidaw_pkg::DIV_D_W];
	assign done  = done_q;
	assign quot  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pidaw_pkg::DIV_CNT_W'(pidaw_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[pidaw_pkg::DIV_D_W-1:0] : trial[pidaw_pkg::DIV_D_W-1:0];
			num_q <= {num_q[pidaw_pkg::DIV_N_W-2:0], qbit};
		end
	end

endmodule

`default_nettype wire

### rtl/pid_controller_antiwindup_top.sv
// Fixed-point PID controller with anti-windup: sequencer, state and output register.
// Depends on pidaw_pkg, pidaw_regs, pidaw_mul and pidaw_div.
//
// Each item (setpoint, feedback) yields one drive/saturated item. The work runs
// on one shift-add multiplier and one restoring divider under a sequencer. An
// item takes the fewest steps with integral and derivative off and the most
// with anti-windup limits, derivative and back-calculation all active. in_stall
// is high while an item is in work; a finished item waits in the output
// register without blocking the next input item. Configuration is written over
// the APB port.
`default_nettype none

module pid_controller_antiwindup_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [15:0]           setpoint,
	input  wire logic signed [15:0]           feedback,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [15:0]                drive,
	output logic                              saturated,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pidaw_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_ILO   = 14'b00000000000010,
		S_IHI   = 14'b00000000000100,
		S_INTEG = 14'b00000000001000,
		S_IMUL  = 14'b00000000010000,
		S_SLOPE = 14'b00000000100000,
		S_FA    = 14'b00000001000000,
		S_FB    = 14'b00000010000000,
		S_DMUL  = 14'b00000100000000,
		S_PMUL  = 14'b00001000000000,
		S_SUM   = 14'b00010000000000,
		S_BACK  = 14'b00100000000000,
		S_DONE  = 14'b01000000000000,
		S_SPARE = 14'b10000000000000
	} state_t;

	function automatic logic signed [50:0] sx48(input logic signed [47:0] x);
		return $signed({{3{x[47]}}, x});
	endfunction

	function automatic logic signed [50:0] sx49(input logic signed [48:0] x);
		return $signed({{2{x[48]}}, x});
	endfunction

	function automatic logic [48:0] mag48(input logic signed [47:0] x);
		logic [48:0] e;
		e = {x[47], x};
		return x[47] ? 49'(-e) : e;
	endfunction

	function automatic logic signed [47:0] clamp_acc(input logic signed [50:0] v);
		logic signed [47:0] r;
		if (v < sx48(pidaw_pkg::ACC_MIN))
			r = pidaw_pkg::ACC_MIN;
		else if (v > sx48(pidaw_pkg::ACC_MAX))
			r = pidaw_pkg::ACC_MAX;
		else
			r = v[47:0];
		return r;
	endfunction

	function automatic logic signed [47:0] clamp_rng(input logic signed [50:0] v,
			input logic signed [47:0] lo, input logic signed [47:0] hi);
		logic signed [47:0] r;
		if (v < sx48(lo))
			r = lo;
		else if (v > sx48(hi))
			r = hi;
		else
			r = v[47:0];
		return r;
	endfunction

	// (|x| * g) >> 16, limited to lim, sign restored
	function automatic logic signed [48:0] scale_sat(
			input logic [pidaw_pkg::MUL_P_W-1:0] p, input logic neg, input logic [48:0] lim);
		logic [pidaw_pkg::MUL_P_W-17:0] r;
		logic [48:0] m;
		r = p[pidaw_pkg::MUL_P_W-1:16];
		m = (r > {{(pidaw_pkg::MUL_P_W-65){1'b0}}, lim}) ? lim : r[48:0];
		return neg ? $signed(49'(-m)) : $signed(m);
	endfunction

	pidaw_pkg::cfg_t cfg;
	state_t          state_q;
	state_t          nxt_unit;
	logic            issued_q;
	logic            out_valid_q;
	logic            first_q;
	logic signed [47:0] isum_q, fs_q;
	logic signed [16:0] last_err_q, err_q;
	logic signed [47:0] ilo_q, ihi_q, slope_q;
	logic signed [48:0] i_q, d_q, fa_q, p_q;
	logic signed [50:0] sumc_q;
	logic [15:0]        drv_q;
	logic               sat_q;
	logic signed [15:0] drive_q;
	logic               saturated_q;

	logic mul_start, mul_done, div_start, div_done;
	logic [pidaw_pkg::MUL_A_W-1:0] mul_a;
	logic [pidaw_pkg::MUL_B_W-1:0] mul_b;
	logic [pidaw_pkg::MUL_P_W-1:0] mul_prod;
	logic [pidaw_pkg::DIV_N_W-1:0] div_num, div_quot;
	logic [pidaw_pkg::DIV_D_W-1:0] div_den;

	logic is_mul, is_div, unit_done, accept, d_on, can_load;
	logic [16:0] alpha, alpha_inv, omin_mag, omax_mag, err_mag;
	logic signed [17:0] diff;
	logic [17:0]        diff_mag;
	logic signed [33:0] ep;
	logic signed [50:0] isum_new, sum_raw, lo_o, hi_o, sum_c, sum_adj, bnum, bq;
	logic [50:0]        bmag;
	logic [48:0]        bsat;
	logic signed [50:0] sq;
	logic               sum_sat;

	pidaw_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	pidaw_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	pidaw_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign pready    = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign saturated = saturated_q;
	assign can_load  = !out_valid_q || !out_stall;
	assign d_on      = (cfg.kd != '0) && !first_q;

	assign alpha     = (cfg.fc > pidaw_pkg::ONE_Q16) ? pidaw_pkg::ONE_Q16 : cfg.fc;
	assign alpha_inv = pidaw_pkg::ONE_Q16 - alpha;
	assign omin_mag  = cfg.omin[15] ? 17'(-{cfg.omin[15], cfg.omin}) : {1'b0, cfg.omin};
	assign omax_mag  = cfg.omax[15] ? 17'(-{cfg.omax[15], cfg.omax}) : {1'b0, cfg.omax};
	assign err_mag   = err_q[16] ? 17'(-err_q) : err_q;
	assign diff      = {err_q[16], err_q} - {last_err_q[16], last_err_q};
	assign diff_mag  = diff[17] ? 18'(-diff) : diff;

	assign ep       = $signed({{17{err_q[16]}}, err_q}) * $signed({18'b0, cfg.per});
	assign isum_new = sx48(isum_q) + $signed({{17{ep[33]}}, ep});

	assign sum_raw = sx49(p_q) + sx49(i_q) + sx49(d_q);
	assign lo_o    = $signed({{19{cfg.omin[15]}}, cfg.omin, 16'b0});
	assign hi_o    = $signed({{19{cfg.omax[15]}}, cfg.omax, 16'b0});

	always_comb begin
		sum_sat = 1'b1;
		if (sum_raw < lo_o)
			sum_c = lo_o;
		else if (sum_raw > hi_o)
			sum_c = hi_o;
		else begin
			sum_c   = sum_raw;
			sum_sat = 1'b0;
		end
	end

	assign sum_adj = sum_c + (sum_c[50] ? 51'sd65535 : 51'sd0);

	assign bnum = sumc_q - sx49(p_q) - sx49(d_q);
	assign bmag = bnum[50] ? 51'(-bnum) : bnum;
	assign bsat = (div_quot > {{(pidaw_pkg::DIV_N_W-49){1'b0}}, 49'h1_0000_0000_0000})
		? 49'h1_0000_0000_0000 : div_quot[48:0];
	assign bq   = bnum[50] ? $signed(51'(-{2'b0, bsat})) : $signed({2'b0, bsat});
	assign sq   = diff[17] ? $signed(51'(-div_quot[50:0])) : $signed(div_quot[50:0]);

	assign is_mul = (state_q == S_IMUL) || (state_q == S_FA) || (state_q == S_FB)
		|| (state_q == S_DMUL) || (state_q == S_PMUL);
	assign is_div = (state_q == S_ILO) || (state_q == S_IHI) || (state_q == S_SLOPE)
		|| (state_q == S_BACK);
	assign mul_start = is_mul && !issued_q;
	assign div_start = is_div && !issued_q;
	assign unit_done = issued_q && ((is_mul && mul_done) || (is_div && div_done));

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		div_num  = '0;
		div_den  = cfg.ki;
		nxt_unit = S_DONE;
		unique case (state_q)
			S_ILO: begin
				div_num  = {17'b0, omin_mag, 32'b0};
				nxt_unit = S_IHI;
			end
			S_IHI: begin
				div_num  = {17'b0, omax_mag, 32'b0};
				nxt_unit = S_INTEG;
			end
			S_IMUL: begin
				mul_a    = mag48(isum_q);
				mul_b    = {1'b0, cfg.ki};
				nxt_unit = d_on ? S_SLOPE : S_PMUL;
			end
			S_SLOPE: begin
				div_num  = {16'b0, diff_mag, 32'b0};
				div_den  = (cfg.per == '0) ? 32'd1 : {16'b0, cfg.per};
				nxt_unit = S_FA;
			end
			S_FA: begin
				mul_a    = mag48(slope_q);
				mul_b    = {16'b0, alpha};
				nxt_unit = S_FB;
			end
			S_FB: begin
				mul_a    = mag48(fs_q);
				mul_b    = {16'b0, alpha_inv};
				nxt_unit = S_DMUL;
			end
			S_DMUL: begin
				mul_a    = mag48(fs_q);
				mul_b    = {1'b0, cfg.kd};
				nxt_unit = S_PMUL;
			end
			S_PMUL: begin
				mul_a    = {32'b0, err_mag};
				mul_b    = {1'b0, cfg.kp};
				nxt_unit = S_SUM;
			end
			S_BACK: begin
				div_num  = {bmag[49:0], 16'b0};
				nxt_unit = S_DONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			isum_q      <= '0;
			last_err_q  <= '0;
			fs_q        <= '0;
			first_q     <= 1'b1;
		end else begin
			if (state_q == S_DONE && can_load)
				out_valid_q <= 1'b1;
			else if (out_stall == 1'b0)
				out_valid_q <= 1'b0;
			if (is_mul || is_div) begin
				if (!issued_q)
					issued_q <= 1'b1;
				else if (unit_done) begin
					issued_q <= 1'b0;
					state_q  <= nxt_unit;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= (cfg.aw && cfg.ki != '0) ? S_ILO : S_INTEG;
				end
				S_INTEG: begin
					if (cfg.ki != '0) begin
						isum_q  <= clamp_rng(sx48(clamp_acc(isum_new)), ilo_q, ihi_q);
						state_q <= S_IMUL;
					end else
						state_q <= d_on ? S_SLOPE : S_PMUL;
				end
				S_FB: begin
					if (unit_done)
						fs_q <= clamp_acc(sx49(fa_q)
							+ sx49(scale_sat(mul_prod, fs_q[47], pidaw_pkg::SLOPE_LIM)));
				end
				S_SUM: begin
					state_q <= (sum_sat && cfg.ki != '0) ? S_BACK : S_DONE;
				end
				S_BACK: begin
					if (unit_done)
						isum_q <= clamp_rng(bq, ilo_q, ihi_q);
				end
				S_DONE: begin
					if (can_load) begin
						last_err_q  <= err_q;
						first_q     <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					err_q <= {setpoint[15], setpoint} - {feedback[15], feedback};
					ilo_q <= pidaw_pkg::ACC_MIN;
					ihi_q <= pidaw_pkg::ACC_MAX;
				end
			end
			S_ILO: begin
				if (unit_done)
					ilo_q <= cfg.omin[15] ? 48'(-div_quot[47:0]) : div_quot[47:0];
			end
			S_IHI: begin
				if (unit_done)
					ihi_q <= cfg.omax[15] ? 48'(-div_quot[47:0]) : div_quot[47:0];
			end
			S_INTEG: begin
				i_q <= '0;
				d_q <= '0;
			end
			S_IMUL: begin
				if (unit_done)
					i_q <= scale_sat(mul_prod, isum_q[47], pidaw_pkg::TERM_LIM);
			end
			S_SLOPE: begin
				if (unit_done)
					slope_q <= clamp_acc(sq);
			end
			S_FA: begin
				if (unit_done)
					fa_q <= scale_sat(mul_prod, slope_q[47], pidaw_pkg::SLOPE_LIM);
			end
			S_DMUL: begin
				if (unit_done)
					d_q <= scale_sat(mul_prod, fs_q[47], pidaw_pkg::TERM_LIM);
			end
			S_PMUL: begin
				if (unit_done)
					p_q <= err_q[16] ? $signed(49'(-mul_prod[48:0])) : $signed(mul_prod[48:0]);
			end
			S_SUM: begin
				sumc_q <= sum_c;
				drv_q  <= sum_adj[31:16];
				sat_q  <= sum_sat;
			end
			S_DONE: begin
				if (can_load) begin
					drive_q     <= $signed(drv_q);
					saturated_q <= sat_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### test/pid_drive_checker.sv
// Checker for the PID controller: tracks register writes, predicts drive/saturated per item
// and compares each output item in order. Depends on pidaw_pkg.
`timescale 1ns / 1ps

module pid_drive_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic signed [15:0]            setpoint,
	input  wire logic signed [15:0]            feedback,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic signed [15:0]            drive,
	input  wire logic                          saturated,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pidaw_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	input  wire logic                          pready,
	output int                                 mismatches,
	output int                                 pending,
	output int                                 checked
);

	localparam longint SUM_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_MIN  = -SUM_MAX - 1;
	localparam longint unsigned TLIM = 64'h0000_0100_0000_0000;
	localparam longint unsigned SLIM = 64'h0000_8000_0000_0000;
	localparam longint TWO32    = 64'sh1_0000_0000;
	localparam longint ONE      = 64'sh1_0000;

	typedef struct {
		logic signed [15:0] drive;
		logic               sat;
	} drive_item_t;

	drive_item_t expected_q[$];

	longint kp, ki, kd, per, fc, omin, omax;
	logic   aw;
	longint integ, last_err, fslope;
	logic   first;

	function automatic longint lim(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint unsigned mag(longint x);
		longint unsigned u;
		u = x;
		return x < 0 ? -u : u;
	endfunction

	function automatic longint scale_q16(longint x, longint g, longint unsigned cap);
		longint unsigned m, gu, p;
		m = mag(x);
		gu = g;
		p = (m >> 16) * gu + (((m & 64'hFFFF) * gu) >> 16);
		if (p > cap)
			p = cap;
		return x < 0 ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint unscale_q16(longint d, longint k);
		longint unsigned m, ku, q, r, p;
		m = mag(d);
		ku = k;
		q = m / ku;
		r = m % ku;
		if (q >= 64'h1_0000_0000)
			p = 64'h1_0000_0000_0000;
		else
			p = (q << 16) + ((r << 16) / ku);
		return d < 0 ? -longint'(p) : longint'(p);
	endfunction

	function automatic drive_item_t predict_drive(longint sp, longint fb);
		drive_item_t res;
		longint err, p_t, i_t, d_t, sum, lo_o, hi_o, ilo, ihi, pd, slope, a;
		logic   sat;
		err = sp - fb;
		p_t = kp * err;
		i_t = 0;
		d_t = 0;
		sat = 0;
		ilo = SUM_MIN;
		ihi = SUM_MAX;
		if (aw && ki != 0) begin
			ilo = lim(omin * TWO32 / ki, SUM_MIN, SUM_MAX);
			ihi = lim(omax * TWO32 / ki, SUM_MIN, SUM_MAX);
		end
		if (ki != 0) begin
			integ = lim(integ + err * per, SUM_MIN, SUM_MAX);
			integ = lim(integ, ilo, ihi);
			i_t = scale_q16(integ, ki, TLIM);
		end
		if (kd != 0 && !first) begin
			pd = per != 0 ? per : 1;
			slope = lim((err - last_err) * TWO32 / pd, SUM_MIN, SUM_MAX);
			a = fc > ONE ? ONE : fc;
			fslope = lim(scale_q16(slope, a, SLIM) + scale_q16(fslope, ONE - a, SLIM),
				SUM_MIN, SUM_MAX);
			d_t = scale_q16(fslope, kd, TLIM);
		end
		sum = p_t + i_t + d_t;
		lo_o = omin * ONE;
		hi_o = omax * ONE;
		if (sum < lo_o) begin
			sum = lo_o;
			sat = 1;
		end else if (sum > hi_o) begin
			sum = hi_o;
			sat = 1;
		end
		if (sat && ki != 0)
			integ = lim(unscale_q16(sum - p_t - d_t, ki), ilo, ihi);
		last_err = err;
		first = 0;
		res.drive = 16'(sum / ONE);
		res.sat = sat;
		return res;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on item %0d: %s got %0d, expected %0d", checked, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_item_t         e;
		pidaw_pkg::reg_idx_t r;
		if (!arst_n) begin
			kp = pidaw_pkg::KP_RST;
			ki = pidaw_pkg::KI_RST;
			kd = pidaw_pkg::KD_RST;
			per = pidaw_pkg::PER_RST;
			fc = pidaw_pkg::FC_RST;
			omin = pidaw_pkg::OMIN_RST;
			omax = pidaw_pkg::OMAX_RST;
			aw = 1;
			integ = 0;
			last_err = 0;
			fslope = 0;
			first = 1;
			expected_q.delete();
			mismatches = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				r = pidaw_pkg::reg_idx_t'(paddr[4:2]);
				unique case (r)
					pidaw_pkg::REG_KP:   kp = pwdata;
					pidaw_pkg::REG_KI:   ki = pwdata;
					pidaw_pkg::REG_KD:   kd = pwdata;
					pidaw_pkg::REG_PER:  per = pwdata[15:0];
					pidaw_pkg::REG_FC:   fc = pwdata[16:0];
					pidaw_pkg::REG_OMIN: omin = $signed(pwdata[15:0]);
					pidaw_pkg::REG_OMAX: omax = $signed(pwdata[15:0]);
					pidaw_pkg::REG_AW:   aw = pwdata[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_drive(setpoint, feedback));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected item drive", drive, 0);
				end else begin
					e = expected_q.pop_front();
					if (drive !== e.drive)
						report_mismatch("drive", drive, e.drive);
					if (saturated !== e.sat)
						report_mismatch("saturated", saturated, e.sat);
				end
				checked++;
			end
			pending = expected_q.size();
		end
	end

endmodule

### test/pid_controller_antiwindup_top_test.sv
// Testbench top for pid_controller_antiwindup_top: clock, reset, APB setup, item stimulus
// and verdict. Depends on pidaw_pkg and pid_drive_checker.
`timescale 1ns / 1ps

module pid_controller_antiwindup_top_test;

	localparam int CYCLE_LIMIT = 3000000;

	logic                           clk = 0;
	logic                           arst_n = 0;
	logic                           in_valid = 0;
	logic                           in_stall;
	logic signed [15:0]             setpoint = 0;
	logic signed [15:0]             feedback = 0;
	logic                           out_valid;
	logic                           out_stall = 0;
	logic signed [15:0]             drive;
	logic                           saturated;
	logic                           psel = 0;
	logic                           penable = 0;
	logic                           pwrite = 0;
	logic [pidaw_pkg::ADDR_W-1:0]   paddr = 0;
	logic [31:0]                    pwdata = 0;
	logic [31:0]                    prdata;
	logic                           pready;

	int  mismatches, pending, checked;
	int  cycles = 0;
	int  items_sent = 0;
	int  phases_run = 0;
	bit  hold_out = 0;
	bit  no_gaps = 0;

	always #1 clk = ~clk;

	pid_controller_antiwindup_top dut (.*);

	pid_drive_checker chk (
		.clk, .arst_n, .in_valid, .in_stall, .setpoint, .feedback, .out_valid, .out_stall,
		.drive, .saturated, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.mismatches, .pending, .checked
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout with %0d items outstanding", pending);
			$display("FAIL");
			$finish;
		end
	end

	// output side: random stalls, free-running stretches, one long hold-off on request
	initial begin
		int r;
		forever begin
			r = $urandom_range(0, 99);
			if (hold_out) begin
				out_stall <= 1;
				repeat (3000) @(posedge clk);
				hold_out = 0;
			end else if (r < 50) begin
				out_stall <= 0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else if (r < 95) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_stall <= 1;
				repeat ($urandom_range(30, 300)) @(posedge clk);
			end
		end
	end

	task automatic reg_write(pidaw_pkg::reg_idx_t r, logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {r, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic wait_idle();
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_item(logic signed [15:0] sp, logic signed [15:0] fb);
		int gap, r;
		r = $urandom_range(0, 99);
		gap = no_gaps ? 0 : (r < 60 ? 0 : (r < 95 ? $urandom_range(1, 5) :
			$urandom_range(20, 200)));
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		setpoint <= sp;
		feedback <= fb;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic send_random();
		int sp, fb;
		if ($urandom_range(0, 99) < 65) begin
			sp = $urandom_range(0, 8000) - 4000;
			fb = sp + $urandom_range(0, 600) - 300;
		end else begin
			sp = $signed(16'($urandom));
			fb = $signed(16'($urandom));
		end
		send_item(16'(sp), 16'(fb));
	endtask

	function automatic logic [31:0] pick_gain(int hi);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom_range(0, hi);
	endfunction

	task automatic random_setup();
		int r, lo, hi;
		reg_write(pidaw_pkg::REG_KP, pick_gain(2000 << 16));
		reg_write(pidaw_pkg::REG_KI, pick_gain(200 << 16));
		reg_write(pidaw_pkg::REG_KD, pick_gain(200 << 16));
		r = $urandom_range(0, 3);
		reg_write(pidaw_pkg::REG_PER,
			r == 0 ? 1 : (r == 1 ? 65535 : $urandom_range(1, 65535)));
		r = $urandom_range(0, 3);
		reg_write(pidaw_pkg::REG_FC,
			r == 0 ? 0 : (r == 1 ? 65536 : $urandom_range(0, 65536)));
		r = $urandom_range(0, 5);
		if (r == 0) begin
			lo = -32768;
			hi = 32767;
		end else if (r == 1) begin
			lo = $urandom_range(0, 1000);
			hi = lo - $urandom_range(1, 1000);
		end else begin
			lo = -$urandom_range(0, 32768);
			hi = $urandom_range(0, 32767);
		end
		reg_write(pidaw_pkg::REG_OMIN, 32'(lo));
		reg_write(pidaw_pkg::REG_OMAX, 32'(hi));
		reg_write(pidaw_pkg::REG_AW, $urandom_range(0, 1));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// reset settings: first sample, field extremes
		send_item(0, 0);
		send_item(100, 0);
		send_item(32767, -32768);
		send_item(-32768, 32767);
		send_item(-32768, -32768);
		send_item(32767, 32767);
		send_item(1000, 990);
		send_item(-5, 5);
		send_item(0, 1);
		in_valid <= 0;
		wait_idle();
		reg_write(pidaw_pkg::REG_KD, 0);
		send_item(500, -500);
		send_item(-20000, 100);
		send_item(3, 0);
		in_valid <= 0;
		wait_idle();
		reg_write(pidaw_pkg::REG_KI, 0);
		reg_write(pidaw_pkg::REG_KD, pidaw_pkg::KD_RST);
		send_item(30000, 0);
		send_item(-3, 2);
		send_item(7, 7);
		in_valid <= 0;
		wait_idle();
		reg_write(pidaw_pkg::REG_KI, pidaw_pkg::KI_RST);
		reg_write(pidaw_pkg::REG_OMIN, 32'(100));
		reg_write(pidaw_pkg::REG_OMAX, 32'(-100));
		send_item(0, 0);
		send_item(32767, 0);
		send_item(-32768, 0);
		in_valid <= 0;
		wait_idle();
		reg_write(pidaw_pkg::REG_AW, 0);
		reg_write(pidaw_pkg::REG_OMIN, 32'(-32768));
		reg_write(pidaw_pkg::REG_OMAX, 32'(32767));
		send_item(32767, -32768);
		send_item(32767, -32768);
		send_item(-32768, 32767);
		in_valid <= 0;
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			random_setup();
			no_gaps = (ph == 2 || ph == 5);
			if (ph == 3)
				hold_out = 1;
			repeat (50) send_random();
			in_valid <= 0;
			no_gaps = 0;
			wait_idle();
			phases_run++;
		end

		repeat (50) @(posedge clk);
		$display("sent %0d items over %0d random register setups plus directed cases",
			items_sent, phases_run);
		$display("checked %0d output items, %0d mismatches", checked, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
